// ===== hdl/dth_pkg.sv =====
// ----------------------------------------------------------------------------
// dth_pkg
// Shared types and constants of the deadline timer heap: command and result
// transaction layouts, heap slot layout and mode codes.
// ----------------------------------------------------------------------------
package dth_pkg;

    localparam int ID_BITS      = 8;
    localparam int TIME_BITS    = 32;
    localparam int CAPACITY     = 64;
    localparam int MAX_RESULTS  = 64;

    typedef enum logic [1:0] {
        MODE_ARM  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ID_BITS-1:0]   timer_id;
        logic [TIME_BITS-1:0] deadline;
        logic [TIME_BITS-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic                 was_pending;
        logic                 full_drop;
        logic                 fired_valid;
        logic [ID_BITS-1:0]   fired_id;
        logic [TIME_BITS-1:0] fired_deadline;
        logic                 last;
    } t_res;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] dl;
    } t_ent;

endpackage

// ===== hdl/deadline_timer_heap_core.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_heap_core
// Binary min-heap of pending timers keyed by deadline, run by a small
// sequencer over one slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_cmd and raise start; the transaction is taken at
//   a rising edge with start high and busy low. busy stays high while the
//   command is worked on; the next command waits for it to drop.
//   Result channel: each result is on o_res for one cycle with o_valid high.
//   The receiver cannot stall, so nothing holds results back.
//   Arm and delete give one result; tick gives one per fired timer (at most
//   MAX_RESULTS) or a single empty result, the final one flagged by last.
// Sequencing:
//   The id search reads one slot per cycle through the memory's registered
//   read port. Sift up steps through ST_UPRD and ST_UPCMP per level, sift
//   down through ST_DNRD, ST_DNC1 and ST_DNC2, and each pop of a tick costs a
//   read of the top, a fetch of the tail slot and a sift down.
// Reset:
//   Synchronous active low reset empties the heap (count zero) and returns the
//   sequencer to idle. Slot contents are not cleared; only slots below the
//   count are ever used.
// ----------------------------------------------------------------------------
module deadline_timer_heap_core #(
    parameter int CAPACITY = dth_pkg::CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  dth_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_valid,
    output dth_pkg::t_res o_res
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int XW    = CW + 1;
    localparam int NW    = $clog2(dth_pkg::MAX_RESULTS + 1);
    localparam int TW    = dth_pkg::TIME_BITS;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SRCH  = 10'b0000000010,
        ST_LRD   = 10'b0000000100,
        ST_LLD   = 10'b0000001000,
        ST_UPRD  = 10'b0000010000,
        ST_UPCMP = 10'b0000100000,
        ST_DNRD  = 10'b0001000000,
        ST_DNC1  = 10'b0010000000,
        ST_DNC2  = 10'b0100000000,
        ST_TKRD  = 10'b1000000000
    } t_state;

    // Slot memory
    dth_pkg::t_ent mem [CAPACITY];
    dth_pkg::t_ent r_rdata;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    dth_pkg::t_ent wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Sequencer state
    t_state        r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic [dth_pkg::ID_BITS-1:0] r_id, n_id;
    logic [TW-1:0] r_dl, n_dl, r_now, n_now;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic          r_dv, n_dv;
    dth_pkg::t_ent r_e, n_e;
    logic [AW-1:0] r_pos, n_pos;
    logic          r_moved, n_moved;
    logic          r_do_down, n_do_down;
    dth_pkg::t_ent r_ch, n_ch;
    logic [AW-1:0] r_chi, n_chi;
    logic          r_two, n_two;
    logic [NW-1:0] r_n, n_n;
    logic          r_hv, n_hv;
    dth_pkg::t_ent r_hold, n_hold;
    logic          r_stb, n_stb;
    dth_pkg::t_res r_res, n_res;

    logic [XW-1:0] child;
    logic [AW-1:0] parent;
    logic [TW-1:0] age;
    logic          found;
    logic          best_r;
    dth_pkg::t_ent best;
    logic [AW-1:0] best_i;
    logic [CW-1:0] cnt_m1;

    assign child  = {{(XW-AW){1'b0}}, r_pos} + {{(XW-AW){1'b0}}, r_pos} + XW'(1);
    assign parent = AW'((r_pos - AW'(1)) >> 1);
    assign age    = r_now - r_rdata.dl;
    assign found  = r_dv && (r_rdata.id == r_id);
    assign best_r = r_two && (r_rdata.dl < r_ch.dl);
    assign best   = best_r ? r_rdata : r_ch;
    assign best_i = best_r ? AW'(r_chi + AW'(1)) : r_chi;
    assign cnt_m1 = r_cnt - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_id      = r_id;
        n_dl      = r_dl;
        n_now     = r_now;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        n_dv      = r_dv;
        n_e       = r_e;
        n_pos     = r_pos;
        n_moved   = r_moved;
        n_do_down = r_do_down;
        n_ch      = r_ch;
        n_chi     = r_chi;
        n_two     = r_two;
        n_n       = r_n;
        n_hv      = r_hv;
        n_hold    = r_hold;
        n_stb     = 1'b0;
        n_res     = '0;
        raddr     = '0;
        we        = 1'b0;
        waddr     = r_pos;
        wdata     = r_e;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode = i_cmd.mode;
                    n_id   = i_cmd.timer_id;
                    n_dl   = i_cmd.deadline;
                    n_now  = i_cmd.now;
                    n_i    = '0;
                    n_dv   = 1'b0;
                    n_n    = '0;
                    n_hv   = 1'b0;
                    case (i_cmd.mode)
                        dth_pkg::MODE_ARM, dth_pkg::MODE_DEL: n_state = ST_SRCH;
                        dth_pkg::MODE_TICK:                   n_state = ST_TKRD;
                        default: begin
                            n_stb      = 1'b1;
                            n_res.last = 1'b1;
                        end
                    endcase
                end
            end

            // Stream slots out one a cycle; the compare works on the registered read data.
            ST_SRCH: begin
                n_moved = 1'b0;
                if (found) begin
                    n_stb             = 1'b1;
                    n_res.last        = 1'b1;
                    n_res.was_pending = 1'b1;
                    n_pos             = r_j;
                    n_do_down         = 1'b1;
                    if (r_mode == dth_pkg::MODE_ARM) begin
                        if (r_rdata.dl == r_dl) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_e     = '{id: r_id, dl: r_dl};
                            n_state = ST_UPRD;
                        end
                    end else begin
                        n_cnt = cnt_m1;
                        if (CW'(r_j) < cnt_m1) begin
                            n_state = ST_LRD;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (r_i < r_cnt) begin
                    raddr = r_i[AW-1:0];
                    n_i   = r_i + CW'(1);
                    n_j   = r_i[AW-1:0];
                    n_dv  = 1'b1;
                end else if (r_dv) begin
                    n_dv = 1'b0;
                end else begin
                    n_stb      = 1'b1;
                    n_res.last = 1'b1;
                    if (r_mode == dth_pkg::MODE_ARM) begin
                        if (r_cnt >= CW'(CAPACITY)) begin
                            n_res.full_drop = 1'b1;
                            n_state         = ST_IDLE;
                        end else begin
                            n_e       = '{id: r_id, dl: r_dl};
                            n_pos     = r_cnt[AW-1:0];
                            n_cnt     = r_cnt + CW'(1);
                            n_do_down = 1'b0;
                            n_state   = ST_UPRD;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            // Fetch the tail slot into the moving entry.
            ST_LRD: begin
                raddr   = r_cnt[AW-1:0];
                n_state = ST_LLD;
            end

            ST_LLD: begin
                n_e     = r_rdata;
                n_state = ST_UPRD;
            end

            ST_UPRD: begin
                if (r_pos == '0) begin
                    if (r_do_down && !r_moved) begin
                        n_state = ST_DNRD;
                    end else begin
                        we      = 1'b1;
                        n_state = (r_mode == dth_pkg::MODE_TICK) ? ST_TKRD : ST_IDLE;
                    end
                end else begin
                    raddr   = parent;
                    n_state = ST_UPCMP;
                end
            end

            // Shift the parent into the hole while the entry is earlier.
            ST_UPCMP: begin
                if (r_e.dl < r_rdata.dl) begin
                    we      = 1'b1;
                    wdata   = r_rdata;
                    n_pos   = parent;
                    n_moved = 1'b1;
                    n_state = ST_UPRD;
                end else if (r_do_down && !r_moved) begin
                    n_state = ST_DNRD;
                end else begin
                    we      = 1'b1;
                    n_state = (r_mode == dth_pkg::MODE_TICK) ? ST_TKRD : ST_IDLE;
                end
            end

            ST_DNRD: begin
                if (child >= XW'(r_cnt)) begin
                    we      = 1'b1;
                    n_state = (r_mode == dth_pkg::MODE_TICK) ? ST_TKRD : ST_IDLE;
                end else begin
                    raddr   = child[AW-1:0];
                    n_state = ST_DNC1;
                end
            end

            ST_DNC1: begin
                n_ch    = r_rdata;
                n_chi   = child[AW-1:0];
                n_two   = (child + XW'(1)) < XW'(r_cnt);
                raddr   = AW'(child + XW'(1));
                n_state = ST_DNC2;
            end

            // Pull the earlier child up while it beats the entry.
            ST_DNC2: begin
                if (best.dl < r_e.dl) begin
                    we      = 1'b1;
                    wdata   = best;
                    n_pos   = best_i;
                    n_state = ST_DNRD;
                end else begin
                    we      = 1'b1;
                    n_state = (r_mode == dth_pkg::MODE_TICK) ? ST_TKRD : ST_IDLE;
                end
            end

            // Tick: read the top, then decide in the next cycle.
            ST_TKRD: begin
                if (r_dv) begin
                    n_dv = 1'b0;
                    if (!age[TW-1]) begin
                        if (r_hv) begin
                            n_stb                = 1'b1;
                            n_res.fired_valid    = 1'b1;
                            n_res.fired_id       = r_hold.id;
                            n_res.fired_deadline = r_hold.dl;
                        end
                        n_hold    = r_rdata;
                        n_hv      = 1'b1;
                        n_n       = r_n + NW'(1);
                        n_cnt     = cnt_m1;
                        n_pos     = '0;
                        n_moved   = 1'b0;
                        n_do_down = 1'b1;
                        if (cnt_m1 != '0) begin
                            n_state = ST_LRD;
                        end
                    end else begin
                        n_stb                = 1'b1;
                        n_res.last           = 1'b1;
                        n_res.fired_valid    = r_hv;
                        n_res.fired_id       = r_hv ? r_hold.id : '0;
                        n_res.fired_deadline = r_hv ? r_hold.dl : '0;
                        n_state              = ST_IDLE;
                    end
                end else if ((r_cnt == '0) || (r_n == NW'(dth_pkg::MAX_RESULTS))) begin
                    n_stb                = 1'b1;
                    n_res.last           = 1'b1;
                    n_res.fired_valid    = r_hv;
                    n_res.fired_id       = r_hv ? r_hold.id : '0;
                    n_res.fired_deadline = r_hv ? r_hold.dl : '0;
                    n_state              = ST_IDLE;
                end else begin
                    raddr = '0;
                    n_dv  = 1'b1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_stb   <= 1'b0;
            r_dv    <= 1'b0;
            r_hv    <= 1'b0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stb   <= n_stb;
            r_dv    <= n_dv;
            r_hv    <= n_hv;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_id      <= n_id;
        r_dl      <= n_dl;
        r_now     <= n_now;
        r_i       <= n_i;
        r_j       <= n_j;
        r_e       <= n_e;
        r_pos     <= n_pos;
        r_moved   <= n_moved;
        r_do_down <= n_do_down;
        r_ch      <= n_ch;
        r_chi     <= n_chi;
        r_two     <= n_two;
        r_hold    <= n_hold;
        r_res     <= n_res;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_stb;
    assign o_res   = r_res;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy without a command");

    a_nonfire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.fired_valid) |-> o_res.last)
        else $error("non-fired result not final");

    a_fire_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.fired_valid) |-> (r_mode == dth_pkg::MODE_TICK))
        else $error("fired result outside tick");

endmodule
